// ===== rtl/core/wabavg_pkg.sv =====
package wabavg_pkg;

    // averaging modes
    localparam logic [1:0] MODE_MEAN = 2'd0;
    localparam logic [1:0] MODE_WRAP = 2'd1;
    localparam logic [1:0] MODE_SUM  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_BND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_BND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN     = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] low_bound;
        logic signed [15:0] high_bound;
        logic signed [31:0] window_low;
        logic signed [31:0] window_high;
        logic [30:0]        wrap_span;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic signed [31:0] value;
        logic               rvalid;
    } t_result;

endpackage

// ===== rtl/core/wabavg_front.sv =====
module wabavg_front
    import wabavg_pkg::*;
#(
    parameter int MAX_BLOCK = 1024,
    localparam int CNT_W = $clog2(MAX_BLOCK + 1),
    localparam int SUM_W = 32 + CNT_W,
    localparam int REC_W = SUM_W + 2 * CNT_W + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_accept,
    input  logic signed [31:0] i_sample,
    input  logic               i_sample_valid,
    input  logic               i_last_sample,
    output logic               o_push,
    output logic [REC_W-1:0]   o_rec
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCK);

    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [CNT_W-1:0]        r_lcnt, n_lcnt;
    logic                    r_low_seen, n_low_seen;
    logic                    r_high_seen, n_high_seen;
    logic signed [16:0]      ipart;
    logic                    take;
    logic                    is_low;
    logic                    is_high;

    // integer part truncated toward zero
    always_comb begin
        ipart = $signed({i_sample[31], i_sample[31:16]})
              + $signed({16'd0, (i_sample[31] & (|i_sample[15:0]))});
    end

    assign take    = i_accept && i_sample_valid && (r_cnt < MAX_CNT);
    assign is_low  = ipart < $signed({i_cfg.low_bound[15], i_cfg.low_bound});
    assign is_high = !is_low && (ipart > $signed({i_cfg.high_bound[15], i_cfg.high_bound}));

    always_comb begin
        n_sum       = r_sum;
        n_cnt       = r_cnt;
        n_lcnt      = r_lcnt;
        n_low_seen  = r_low_seen;
        n_high_seen = r_high_seen;
        if (take) begin
            n_sum = r_sum + SUM_W'(i_sample);
            n_cnt = r_cnt + 1'b1;
            if (is_low) begin
                n_lcnt     = r_lcnt + 1'b1;
                n_low_seen = 1'b1;
            end
            if (is_high) begin
                n_high_seen = 1'b1;
            end
        end
    end

    assign o_push = i_accept && i_last_sample;
    assign o_rec  = {n_sum, n_cnt, n_lcnt, (n_low_seen & n_high_seen)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_lcnt      <= '0;
            r_low_seen  <= 1'b0;
            r_high_seen <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_lcnt      <= n_lcnt;
            r_low_seen  <= n_low_seen;
            r_high_seen <= n_high_seen;
        end
    end

endmodule

// ===== rtl/core/wabavg_fifo.sv =====
module wabavg_fifo
    import wabavg_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_status    o_status
);

    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_level;
    logic         do_push;
    logic         do_pop;

    assign o_status.full  = (r_level == 2'd2);
    assign o_status.empty = (r_level == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_level <= r_level + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/wabavg_back.sv =====
module wabavg_back
    import wabavg_pkg::*;
#(
    parameter int MAX_BLOCK = 1024,
    localparam int CNT_W = $clog2(MAX_BLOCK + 1),
    localparam int SUM_W = 32 + CNT_W,
    localparam int REC_W = SUM_W + 2 * CNT_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_q_status        i_q_status,
    input  logic [REC_W-1:0] i_rec,
    output logic             o_pop,
    output logic             o_res_valid,
    output t_result          o_res,
    input  logic             i_res_ack
);

    localparam int PROD_W = CNT_W + 31;
    localparam int TOT_W  = SUM_W + 1;
    localparam int MEAN_W = TOT_W + 1;
    localparam int IT_W   = $clog2(TOT_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_ABS  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SIGN = 3'd5;
    localparam logic [2:0] S_FOLD = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]               r_state;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_lcnt;
    logic                     r_pair;
    logic [PROD_W-1:0]        r_prod;
    logic signed [TOT_W-1:0]  r_tot;
    logic                     r_neg;
    logic [TOT_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_rem;
    logic [IT_W-1:0]          r_it;
    logic signed [MEAN_W-1:0] r_mean;
    logic                     r_rvalid;

    logic [CNT_W:0]           rem_sh;
    logic                     rem_ge;
    logic [TOT_W-1:0]         tot_mag;
    logic signed [MEAN_W-1:0] win_hi;
    logic signed [MEAN_W-1:0] win_lo;
    logic signed [MEAN_W-1:0] span_x;
    logic [MEAN_W-32:0]       mean_top;

    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[TOT_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_cnt};

    assign tot_mag = r_tot[TOT_W-1] ? TOT_W'(-r_tot) : TOT_W'(r_tot);
    assign win_hi  = MEAN_W'(i_cfg.window_high);
    assign win_lo  = MEAN_W'(i_cfg.window_low);
    assign span_x  = $signed({{(MEAN_W-31){1'b0}}, i_cfg.wrap_span});

    // saturation to Q16.16
    assign mean_top    = r_mean[MEAN_W-1:31];
    assign o_res_valid = (r_state == S_OUT);
    assign o_res.rvalid = r_rvalid;
    always_comb begin
        if ((&mean_top) || !(|mean_top)) begin
            o_res.value = r_mean[31:0];
        end else if (r_mean[MEAN_W-1]) begin
            o_res.value = 32'sh8000_0000;
        end else begin
            o_res.value = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_pop) r_state <= S_MUL;
                S_MUL:  r_state <= S_ADD;
                S_ADD: begin
                    if (i_cfg.mode == MODE_SUM || r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS:  r_state <= S_DIV;
                S_DIV:  if (r_it == IT_W'(1)) r_state <= S_SIGN;
                S_SIGN: r_state <= S_FOLD;
                S_FOLD: r_state <= S_OUT;
                S_OUT:  if (i_res_ack) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    {r_sum, r_cnt, r_lcnt, r_pair} <= i_rec;
                end
            end
            S_MUL: begin
                if (i_cfg.mode == MODE_WRAP && r_pair) begin
                    r_prod <= PROD_W'(r_lcnt * i_cfg.wrap_span);
                end else begin
                    r_prod <= '0;
                end
            end
            S_ADD: begin
                r_tot <= TOT_W'(r_sum) + $signed({{(TOT_W-PROD_W){1'b0}}, r_prod});
                if (i_cfg.mode == MODE_SUM) begin
                    r_mean   <= MEAN_W'(r_sum);
                    r_rvalid <= 1'b1;
                end else if (r_cnt == '0) begin
                    r_mean   <= '0;
                    r_rvalid <= 1'b0;
                end else begin
                    r_rvalid <= 1'b1;
                end
            end
            S_ABS: begin
                r_neg <= r_tot[TOT_W-1];
                r_quo <= tot_mag + TOT_W'(r_cnt >> 1);
                r_rem <= '0;
                r_it  <= IT_W'(TOT_W);
            end
            S_DIV: begin
                if (rem_ge) begin
                    r_rem <= CNT_W'(rem_sh - {1'b0, r_cnt});
                end else begin
                    r_rem <= rem_sh[CNT_W-1:0];
                end
                r_quo <= {r_quo[TOT_W-2:0], rem_ge};
                r_it  <= r_it - 1'b1;
            end
            S_SIGN: begin
                if (r_neg) begin
                    r_mean <= -$signed({1'b0, r_quo});
                end else begin
                    r_mean <= $signed({1'b0, r_quo});
                end
            end
            S_FOLD: begin
                if (i_cfg.mode == MODE_WRAP) begin
                    priority if (r_mean > win_hi) begin
                        r_mean <= r_mean - span_x;
                    end else if (r_mean < win_lo) begin
                        r_mean <= r_mean + span_x;
                    end else begin
                        r_mean <= r_mean;
                    end
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/wrap_aware_block_average_unit.sv =====
// Block averager for signed Q16.16 samples. Samples stream in one per cycle
// unless the input is stalled, each with a valid flag (low for a missing
// sample) and a last marker that closes the block. The front end accumulates
// sum, count and low/high classification at one sample per clock unless
// stalled and hands each closed block to a two-entry request queue; the back
// end turns it into one result: the saturated sum (mode 2), the rounded mean
// (mode 0, also mode 3), or the mean with modulo wrap (mode 1), where low
// samples are lifted by wrap_span when the block holds both low and high
// samples, and the mean is folded once into [window_low, window_high]. A
// mean of an empty block comes out as value 0 with result_valid low. Valid
// samples beyond MAX_BLOCK in one block are ignored. Throughput: one sample
// per cycle inside a block while the queue has room. For a mean the back
// end steps through multiply, add, magnitude, a bit-serial divide making one
// quotient bit per clock, sign and fold; sum or empty blocks skip from add
// to output; with two blocks queued, blocks shorter than a pass stall input.
// Configuration writes are taken in any cycle and belong only in idle
// periods.
module wrap_aware_block_average_unit
    import wabavg_pkg::*;
#(
    parameter int MAX_BLOCK = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_sample,
    input  logic                  i_sample_valid,
    input  logic                  i_last_sample,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_result_value,
    output logic                  o_result_valid,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W = 32 + CNT_W;
    localparam int REC_W = SUM_W + 2 * CNT_W + 1;

    t_cfg             r_cfg;
    t_q_status        q_status;
    logic             in_accept;
    logic             push;
    logic [REC_W-1:0] push_rec;
    logic             pop;
    logic [REC_W-1:0] pop_rec;
    logic             res_valid;
    t_result          res;
    logic             out_free;
    logic             out_load;
    logic             r_o_valid;
    t_result          r_out;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_MODE:     r_cfg.mode        <= i_cfg_data[1:0];
                REG_LOW_BND:  r_cfg.low_bound   <= i_cfg_data[15:0];
                REG_HIGH_BND: r_cfg.high_bound  <= i_cfg_data[15:0];
                REG_WIN_LOW:  r_cfg.window_low  <= i_cfg_data[31:0];
                REG_WIN_HIGH: r_cfg.window_high <= i_cfg_data[31:0];
                REG_SPAN:     r_cfg.wrap_span   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // the front end stalls only when the block queue has no room
    assign o_stall   = q_status.full;
    assign in_accept = i_valid && !o_stall;

    wabavg_front #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_accept      (in_accept),
        .i_sample      (i_sample),
        .i_sample_valid(i_sample_valid),
        .i_last_sample (i_last_sample),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    wabavg_fifo #(
        .W(REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_rec),
        .i_pop   (pop),
        .o_data  (pop_rec),
        .o_status(q_status)
    );

    wabavg_back #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_rec      (pop_rec),
        .o_pop      (pop),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ack  (out_free)
    );

    // output register: the back end may finish the next block while this
    // result waits
    assign out_free = !r_o_valid || !i_stall;
    assign out_load = res_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_result_value = r_out.value;
    assign o_result_valid = r_out.rvalid;

    // a closed block never meets a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("block pushed into full queue");

    // an empty-block mean carries value zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_valid |-> o_result_value == 32'sd0)
        else $error("invalid result with nonzero value");

    // a pending result is not overwritten while stalled
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && i_stall |-> !out_load)
        else $error("output register loaded while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

// ===== tb/wrap_aware_block_average_unit_tb.sv =====
module wrap_aware_block_average_unit_tb;
    import wabavg_pkg::*;

    // --------------------------------------------------------------------
    // Run constants
    // --------------------------------------------------------------------
    localparam int BLOCK_CAP        = 1024;     // valid samples kept per block
    localparam int DEG              = 65536;    // one integer unit in Q16.16
    localparam int RESET_CYCLES     = 8;
    localparam int IDLE_PCT         = 9;        // chance of an idle cycle, per side
    localparam int SETTLE_CYCLES    = 150;      // > two back-end passes
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_SAMPLES    = 12;

    // mode 3 has no name in the package; it must act as the plain mean
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // --------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // --------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_stall;
    logic signed [31:0]    i_sample       = '0;
    logic                  i_sample_valid = 1'b0;
    logic                  i_last_sample  = 1'b0;
    logic                  o_valid;
    logic                  i_stall        = 1'b0;
    logic signed [31:0]    o_result_value;
    logic                  o_result_valid;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    wrap_aware_block_average_unit #(
        .MAX_BLOCK(BLOCK_CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_sample_valid (i_sample_valid),
        .i_last_sample  (i_last_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_result_valid (o_result_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // --------------------------------------------------------------------
    // Block-average prediction state: register shadow and the open block
    // --------------------------------------------------------------------
    t_cfg    shadow_cfg = '0;
    longint  blk_sum;
    longint  blk_count;
    longint  blk_low_count;
    bit      blk_low_seen;
    bit      blk_high_seen;
    t_result pending_block_results[$];

    // idle knobs and bookkeeping
    bit tx_idle_on      = 1'b1;
    bit rx_idle_on      = 1'b1;
    bit long_hold_armed = 1'b0;
    int mismatches      = 0;
    int blocks_checked  = 0;
    int samples_sent    = 0;
    int setups_loaded   = 0;
    int long_holds      = 0;
    int cycles          = 0;

    // --------------------------------------------------------------------
    // Clock and watchdog
    // --------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycles, pending_block_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // --------------------------------------------------------------------
    // Prediction
    // --------------------------------------------------------------------
    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[31:0];
    endfunction

    // Folds one accepted sample into the open block; on the closing sample
    // it queues the block's mean or sum and opens a fresh block.
    task automatic accumulate_sample(input logic signed [31:0] s, input logic sv,
                                     input logic last);
        longint  ipart;
        longint  total;
        longint  mag;
        longint  quo;
        longint  span;
        t_result r;
        span = longint'(shadow_cfg.wrap_span);
        if (sv && blk_count < BLOCK_CAP) begin
            ipart = longint'(s) / DEG;          // truncates toward zero
            blk_sum += longint'(s);
            blk_count++;
            if (ipart < longint'($signed(shadow_cfg.low_bound))) begin
                blk_low_seen = 1'b1;
                blk_low_count++;
            end else if (ipart > longint'($signed(shadow_cfg.high_bound))) begin
                blk_high_seen = 1'b1;
            end
        end
        if (last) begin
            r.rvalid = 1'b1;
            if (shadow_cfg.mode == MODE_SUM) begin
                r.value = clamp_q16(blk_sum);
            end else if (blk_count == 0) begin
                r.value  = '0;
                r.rvalid = 1'b0;
            end else begin
                total = blk_sum;
                if (shadow_cfg.mode == MODE_WRAP && blk_low_seen && blk_high_seen)
                    total += blk_low_count * span;
                // round half away from zero
                mag = (total < 0) ? -total : total;
                quo = (mag + blk_count / 2) / blk_count;
                if (total < 0)
                    quo = -quo;
                if (shadow_cfg.mode == MODE_WRAP) begin
                    if (quo > longint'($signed(shadow_cfg.window_high)))
                        quo -= span;
                    else if (quo < longint'($signed(shadow_cfg.window_low)))
                        quo += span;
                end
                r.value = clamp_q16(quo);
            end
            pending_block_results.push_back(r);
            blk_sum       = 0;
            blk_count     = 0;
            blk_low_count = 0;
            blk_low_seen  = 1'b0;
            blk_high_seen = 1'b0;
        end
    endtask

    // --------------------------------------------------------------------
    // Result side: random stall plus the occasional long hold-off
    // --------------------------------------------------------------------
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                long_holds++;
                repeat (LONG_HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0d: %s", cycles, what);
    endtask

    // Every accepted result is held against the oldest awaited one.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_block_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result value=%0d valid=%0b",
                                        o_result_value, o_result_valid));
            end else begin
                want = pending_block_results.pop_front();
                blocks_checked++;
                if (o_result_value !== want.value)
                    flag_mismatch($sformatf("block %0d value %0d, want %0d",
                                            blocks_checked, o_result_value, want.value));
                if (o_result_valid !== want.rvalid)
                    flag_mismatch($sformatf("block %0d valid %0b, want %0b",
                                            blocks_checked, o_result_valid, want.rvalid));
            end
        end
    end

    // --------------------------------------------------------------------
    // Request side
    // --------------------------------------------------------------------
    // valid stays high from one request to the next unless an idle is drawn
    task automatic send_sample(input logic signed [31:0] s, input logic sv,
                               input logic last);
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample       <= s;
        i_sample_valid <= sv;
        i_last_sample  <= last;
        do
            @(posedge i_clk);
        while (o_stall);
        samples_sent++;
        accumulate_sample(s, sv, last);
    endtask

    // One block of random samples, biased toward the low/high thresholds
    // and the wrap period of the current setup.
    task automatic send_block(input int len, input int valid_pct);
        logic signed [31:0] s;
        logic [15:0]        ipart;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: s = $urandom;
                3, 4: begin
                    ipart = 16'(shadow_cfg.low_bound + $urandom_range(0, 4) - 2);
                    s = {ipart, 16'($urandom)};
                end
                5, 6: begin
                    ipart = 16'(shadow_cfg.high_bound + $urandom_range(0, 4) - 2);
                    s = {ipart, 16'($urandom)};
                end
                7: s = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
                default: begin
                    if (shadow_cfg.wrap_span != 0)
                        s = 32'($urandom_range(0, shadow_cfg.wrap_span - 1));
                    else
                        s = 32'($urandom_range(0, 2097151)) - 32'sd1048576;
                end
            endcase
            send_sample(s, $urandom_range(0, 99) < valid_pct, k == len - 1);
        end
    endtask

    // Registers are only touched here, with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            REG_MODE:     shadow_cfg.mode        = data[1:0];
            REG_LOW_BND:  shadow_cfg.low_bound   = data[15:0];
            REG_HIGH_BND: shadow_cfg.high_bound  = data[15:0];
            REG_WIN_LOW:  shadow_cfg.window_low  = data;
            REG_WIN_HIGH: shadow_cfg.window_high = data;
            REG_SPAN:     shadow_cfg.wrap_span   = data[30:0];
            default: ;
        endcase
    endtask

    // junk fills the bits each register ignores
    task automatic load_setup(input logic [1:0] mode,
                              input logic signed [15:0] lo, input logic signed [15:0] hi,
                              input logic signed [31:0] wlo, input logic signed [31:0] whi,
                              input logic [30:0] span, input logic [31:0] junk);
        write_reg(REG_MODE,     {junk[31:2], mode});
        write_reg(REG_LOW_BND,  {junk[31:16], lo});
        write_reg(REG_HIGH_BND, {junk[31:16], hi});
        write_reg(REG_WIN_LOW,  wlo);
        write_reg(REG_WIN_HIGH, whi);
        write_reg(REG_SPAN,     {junk[31], span});
        i_cfg_valid <= 1'b0;
        setups_loaded++;
    endtask

    // angle-style, fully random, or one of two corner setups
    task automatic pick_setup(input logic [1:0] mode);
        logic signed [31:0] wlo;
        case ($urandom_range(0, 3))
            0: begin
                wlo = $urandom_range(0, 1) ? -180 * DEG : 0;
                load_setup(mode, 16'($urandom_range(0, 90)), 16'($urandom_range(270, 359)),
                           wlo, wlo + 360 * DEG - 1, 31'(360 * DEG), $urandom);
            end
            1: load_setup(mode, 16'($urandom), 16'($urandom), $urandom, $urandom,
                          31'($urandom), $urandom);
            2: load_setup(mode, 16'sh8000, 16'sh7FFF, Q_MIN, Q_MAX, 31'h7FFF_FFFF, $urandom);
            default: load_setup(mode, 16'sh7FFF, 16'sh8000, Q_MAX, Q_MIN,
                                $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd0, $urandom);
        endcase
    endtask

    // Close a phase: stop requests, collect every awaited result, then give
    // the back end time to finish anything still in flight.
    task automatic finish_phase();
        i_valid <= 1'b0;
        while (pending_block_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // --------------------------------------------------------------------
    // Tests
    // --------------------------------------------------------------------
    // Reset settings: plain mean, all bounds zero.
    task automatic test_reset_state();
        send_sample(Q_MAX, 1'b1, 1'b0);
        send_sample(Q_MAX, 1'b1, 1'b1);
        send_sample(Q_MIN, 1'b1, 1'b1);
        send_sample(Q_MAX, 1'b0, 1'b1);     // empty block: mean is invalid
        send_sample(32'sd1, 1'b1, 1'b0);    // 1/2: tie rounds away from zero
        send_sample(32'sd0, 1'b1, 1'b1);
        send_sample(Q_MAX, 1'b1, 1'b0);     // -1/2: tie rounds to -1
        send_sample(Q_MIN, 1'b1, 1'b1);
        finish_phase();
    endtask

    task automatic test_sum_mode();
        load_setup(MODE_SUM, '0, '0, '0, '0, '0, '0);
        send_sample(Q_MAX, 1'b1, 1'b0);     // saturates high
        send_sample(Q_MAX, 1'b1, 1'b1);
        send_sample(Q_MIN, 1'b1, 1'b0);     // saturates low
        send_sample(Q_MIN, 1'b1, 1'b1);
        send_sample(32'sd5, 1'b0, 1'b1);    // sum of nothing is a valid zero
        finish_phase();
    endtask

    task automatic test_spare_mode();
        load_setup(MODE_SPARE, '0, '0, '0, '0, '0, '0);
        send_sample(32'sd3, 1'b1, 1'b0);
        send_sample(32'sd4, 1'b1, 1'b1);
        send_sample(32'sd9, 1'b0, 1'b1);
        finish_phase();
    endtask

    // Degree wrap: lows below 10, highs above 350, window [0, 360).
    task automatic test_wrap_mode();
        load_setup(MODE_WRAP, 16'sd10, 16'sd350, '0, 360 * DEG - 1, 31'(360 * DEG), '0);
        send_sample(355 * DEG, 1'b1, 1'b0); // lifted mean lands on 360, folds to 0
        send_sample(5 * DEG, 1'b1, 1'b1);
        send_sample(-32'sd32768, 1'b1, 1'b0);   // -0.5 has integer part 0: low
        send_sample(355 * DEG, 1'b1, 1'b1);
        send_sample(1 * DEG, 1'b1, 1'b0);   // lows only: no lift
        send_sample(2 * DEG, 1'b1, 1'b1);
        finish_phase();
    endtask

    // Valid samples past the cap are dropped, including their low/high marks;
    // a missing sample early on does not count toward the cap.
    task automatic test_overlong_block();
        logic signed [31:0] s;
        load_setup(MODE_WRAP, 16'sd10, 16'sd350, '0, 360 * DEG - 1, 31'(360 * DEG), '0);
        for (int k = 0; k < BLOCK_CAP + 11; k++) begin
            if (k <= BLOCK_CAP)
                s = 32'($urandom_range(100 * DEG, 300 * DEG));
            else
                s = k[0] ? 5 * DEG : 355 * DEG;
            send_sample(s, k != 3, k == BLOCK_CAP + 10);
        end
        finish_phase();
    endtask

    // Receiver holds off while short blocks keep coming, so the request
    // queue fills and the input has to stall.
    task automatic test_output_backpressure();
        pick_setup(MODE_WRAP);
        tx_idle_on      = 1'b0;
        rx_idle_on      = 1'b0;
        long_hold_armed = 1'b1;
        repeat (40) send_block(2, 90);
        finish_phase();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_blocks();
        int         sent_here;
        int         len;
        int         roll;
        logic [1:0] mode;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1:       mode = MODE_MEAN;
                2:       mode = MODE_SUM;
                4:       mode = MODE_SPARE;
                default: mode = MODE_WRAP;
            endcase
            pick_setup(mode);
            // one phase runs flat out on both sides
            tx_idle_on = (phase != 3);
            rx_idle_on = (phase != 3);
            sent_here  = 0;
            while (sent_here < PHASE_SAMPLES) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    len = $urandom_range(1, 8);
                else if (roll < 95)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 120);
                send_block(len, ($urandom_range(0, 19) == 0) ? 0 : 85);
                sent_here += len;
            end
            finish_phase();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // --------------------------------------------------------------------
    // Sequence
    // --------------------------------------------------------------------
    initial begin : run
        blk_sum       = 0;
        blk_count     = 0;
        blk_low_count = 0;
        blk_low_seen  = 1'b0;
        blk_high_seen = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_sum_mode();
        test_spare_mode();
        test_wrap_mode();
        test_overlong_block();
        test_output_backpressure();
        test_random_blocks();

        $display("covered %0d samples, %0d block results, %0d register setups",
                 samples_sent, blocks_checked, setups_loaded);
        $display("all modes, empty and over-cap blocks, %0d long output hold-off(s)",
                 long_holds);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
